// File: rtl/core/oir_pkg.sv
// Shared types and constants for the ordered ID registry.
package oir_pkg;

   localparam logic [7:0] EMPTY_MARK = 8'hFF;

   typedef enum logic [2:0] {
      OP_REGISTER   = 3'd0,
      OP_UNREGISTER = 3'd1,
      OP_QUERY      = 3'd2,
      OP_READ_AT    = 3'd3,
      OP_MOVE       = 3'd4
   } oir_op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_CHANGE = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_RANGE     = 3'd4
   } oir_status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SEARCH,
      FSM_EXEC
   } oir_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic search;
      logic execute;
   } oir_cmd_type;

endpackage

// File: rtl/core/oir_ctrl.sv
// Controller state machine: sequences capture, search and execute of one request.
module oir_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output oir_pkg::oir_cmd_type cmd
);

   oir_pkg::oir_state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= oir_pkg::FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      unique case (state_ff)
         oir_pkg::FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = oir_pkg::FSM_SEARCH;
            end
         end
         oir_pkg::FSM_SEARCH: begin
            cmd.search = 1'b1;
            state_in   = oir_pkg::FSM_EXEC;
         end
         oir_pkg::FSM_EXEC: begin
            // The result register must be free before the list is updated.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.execute = 1'b1;
               state_in    = oir_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = oir_pkg::FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/core/oir_dp.sv
// Datapath: row of slot cells with parallel compare, shift network and result registers.
module oir_dp #(
   parameter int ENTRIES = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  oir_pkg::oir_cmd_type cmd,
   input  logic [2:0]           req_command,
   input  logic [7:0]           req_item_id,
   input  logic [4:0]           req_position,
   output logic [2:0]           rsp_status,
   output logic                 rsp_present,
   output logic [7:0]           rsp_entry_id,
   output logic [4:0]           rsp_final_position,
   output logic [5:0]           rsp_entry_count
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int PW    = (CNT_W > 5) ? CNT_W : 5;

   logic [7:0]       slots_ff [ENTRIES];
   logic [7:0]       slots_in [ENTRIES];
   logic [CNT_W-1:0] count_ff, count_in;

   logic [2:0]       command_ff;
   logic [7:0]       item_id_ff;
   logic [4:0]       position_ff;

   logic             found_ff, found_in;
   logic [IDX_W-1:0] k_ff, k_in;

   logic [2:0]       status_ff, status_in;
   logic             present_ff, present_in;
   logic [7:0]       entry_ff, entry_in;
   logic [4:0]       fpos_ff, fpos_in;
   logic [5:0]       rcount_ff, rcount_in;

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         command_ff  <= req_command;
         item_id_ff  <= req_item_id;
         position_ff <= req_position;
      end
   end

   // Parallel compare against every slot; IDs are distinct, so at most one hits.
   always_comb begin
      found_in = 1'b0;
      k_in     = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (slots_ff[i] == item_id_ff && item_id_ff != oir_pkg::EMPTY_MARK) begin
            found_in = 1'b1;
            k_in     = k_in | IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search) begin
         found_ff <= found_in;
         k_ff     <= k_in;
      end
   end

   logic [PW-1:0]    pos_w, k_w, last_w, adj_w, tgt_w;
   logic             pos_oor;
   logic [IDX_W-1:0] pos_idx;
   logic [7:0]       up_slot [ENTRIES];
   logic [7:0]       dn_slot [ENTRIES];

   always_comb begin
      pos_w   = PW'(position_ff);
      k_w     = PW'(k_ff);
      pos_oor = (pos_w >= PW'(ENTRIES));
      pos_idx = IDX_W'(position_ff);
      // After removal the list holds count - 1 entries; the target may not pass them.
      last_w  = PW'(count_ff) - PW'(1);
      adj_w   = (k_w < pos_w) ? (pos_w - PW'(1)) : pos_w;
      tgt_w   = (adj_w > last_w) ? last_w : adj_w;
      for (int i = 0; i < ENTRIES; i++) begin
         up_slot[i] = (i == ENTRIES - 1) ? oir_pkg::EMPTY_MARK
                                         : slots_ff[(i == ENTRIES - 1) ? i : i + 1];
         dn_slot[i] = (i == 0) ? oir_pkg::EMPTY_MARK : slots_ff[(i == 0) ? i : i - 1];
      end
   end

   always_comb begin
      slots_in   = slots_ff;
      count_in   = count_ff;
      status_in  = oir_pkg::ST_NO_CHANGE;
      entry_in   = oir_pkg::EMPTY_MARK;
      fpos_in    = '0;
      present_in = found_ff;
      unique case (command_ff)
         oir_pkg::OP_REGISTER: begin
            if (item_id_ff == oir_pkg::EMPTY_MARK || found_ff) begin
               status_in = oir_pkg::ST_NO_CHANGE;
            end else if (count_ff == CNT_W'(ENTRIES)) begin
               status_in = oir_pkg::ST_FULL;
            end else begin
               slots_in[IDX_W'(count_ff)] = item_id_ff;
               count_in   = count_ff + CNT_W'(1);
               status_in  = oir_pkg::ST_OK;
               present_in = 1'b1;
            end
         end
         oir_pkg::OP_UNREGISTER: begin
            if (!found_ff) begin
               status_in = oir_pkg::ST_NOT_FOUND;
            end else begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (i >= int'(k_ff)) begin
                     slots_in[i] = up_slot[i];
                  end
               end
               count_in   = count_ff - CNT_W'(1);
               status_in  = oir_pkg::ST_OK;
               present_in = 1'b0;
            end
         end
         oir_pkg::OP_QUERY: begin
            status_in = oir_pkg::ST_OK;
         end
         oir_pkg::OP_READ_AT: begin
            if (pos_oor) begin
               status_in = oir_pkg::ST_RANGE;
            end else begin
               entry_in  = slots_ff[pos_idx];
               status_in = oir_pkg::ST_OK;
            end
         end
         oir_pkg::OP_MOVE: begin
            if (pos_oor) begin
               status_in = oir_pkg::ST_RANGE;
            end else if (!found_ff) begin
               status_in = oir_pkg::ST_NOT_FOUND;
            end else begin
               // Each cell takes its own slot, a neighbor, or the moved ID.
               for (int i = 0; i < ENTRIES; i++) begin
                  if (i == int'(tgt_w)) begin
                     slots_in[i] = item_id_ff;
                  end else if (i < int'(tgt_w)) begin
                     slots_in[i] = (i < int'(k_ff)) ? slots_ff[i] : up_slot[i];
                  end else begin
                     slots_in[i] = (i <= int'(k_ff)) ? dn_slot[i] : slots_ff[i];
                  end
               end
               fpos_in   = 5'(tgt_w);
               status_in = oir_pkg::ST_OK;
            end
         end
         default: begin
            status_in = oir_pkg::ST_NO_CHANGE;
         end
      endcase
      rcount_in = 6'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            slots_ff[i] <= oir_pkg::EMPTY_MARK;
         end
         count_ff <= '0;
      end else if (cmd.execute) begin
         slots_ff <= slots_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff  <= status_in;
         present_ff <= present_in;
         entry_ff   <= entry_in;
         fpos_ff    <= fpos_in;
         rcount_ff  <= rcount_in;
      end
   end

   assign rsp_status         = status_ff;
   assign rsp_present        = present_ff;
   assign rsp_entry_id       = entry_ff;
   assign rsp_final_position = fpos_ff;
   assign rsp_entry_count    = rcount_ff;

endmodule

// File: rtl/core/ordered_id_registry.sv
// Ordered ID registry: compact list of distinct IDs with register, remove, query, read and move.
// A transferred request passes the controller sequence capture, compare and update; the
// result is registered by the update, which waits while the previous result is still
// untaken. A new request is accepted only once the update of the last one is done.
// Reset: synchronous, active high; all slots read empty and the entry count is zero.
// Requests are taken while a finished result waits in the output register.
module ordered_id_registry #(
   parameter int ENTRIES = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_command,
   input  logic [7:0] req_item_id,
   input  logic [4:0] req_position,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic       rsp_present,
   output logic [7:0] rsp_entry_id,
   output logic [4:0] rsp_final_position,
   output logic [5:0] rsp_entry_count
);

   oir_pkg::oir_cmd_type cmd;

   oir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   oir_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_command        (req_command),
      .req_item_id        (req_item_id),
      .req_position       (req_position),
      .rsp_status         (rsp_status),
      .rsp_present        (rsp_present),
      .rsp_entry_id       (rsp_entry_id),
      .rsp_final_position (rsp_final_position),
      .rsp_entry_count    (rsp_entry_count)
   );

   // The list is only updated when the result register can take the new result.
   a_exec_free: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> (!rsp_valid || rsp_ready))
      else $error("update issued while result register still occupied");

   // An accepted request is compared against the list in the following cycle.
   a_accept_search: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (cmd.search && !req_ready))
      else $error("accepted request did not enter the compare step");

   // Every update produces a valid result on the next cycle.
   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_valid)
      else $error("update without a following result");

   // Only a successful move reports a nonzero final position.
   a_fpos_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != oir_pkg::ST_OK) |-> (rsp_final_position == 5'd0))
      else $error("final position set on a failed command");

endmodule
